/* rtl/sctt_pkg.sv */
// Shared types, constants and helpers for the scan chain TAP table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sctt_pkg;

  localparam int MAX_DEVICES_DEF = 16;

  // field widths
  localparam int KIND_W   = 2;
  localparam int POS_W    = 5;
  localparam int LEN_W    = 6;
  localparam int ID_W     = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int EPOS_W   = 4;
  localparam int MASK_W   = 32;
  localparam int DEV_W    = 4;
  localparam int SUM_W    = 9;

  localparam int IN_FIELDS_W  = POS_W + LEN_W + ID_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = COUNT_W + EPOS_W + LEN_W + MASK_W + ID_W
                                + 2 * DEV_W + 2 * SUM_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_PURGE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd2;
  localparam logic [KIND_W-1:0] KIND_GET    = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;

  // one table entry as stored
  typedef struct packed {
    logic [SUM_W-1:0] bits_ahead;
    logic [LEN_W-1:0] len;
    logic [ID_W-1:0]  id;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic decode;
    logic shift_rd;
    logic drain;
    logic place;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_purge;
    logic is_get;
    logic err;
    logic shift_needed;
    logic last_rd;
  } sts_t;

  // low len bits set; 32 or more saturates to all ones
  function automatic logic [MASK_W-1:0] ir_mask(input logic [LEN_W-1:0] len);
    logic [MASK_W-1:0] m;
    if (len >= LEN_W'(MASK_W)) begin
      m = '1;
    end else begin
      m = (MASK_W'(1) << len[4:0]) - MASK_W'(1);
    end
    return m;
  endfunction

endpackage

/* rtl/scan_chain_tap_table.sv */
// Top level of the scan chain TAP table: controller plus datapath.
// Depends on sctt_pkg, sctt_ctrl and sctt_datapath.
//
// Channel | Dir | Ports                         | Payload
// --------+-----+-------------------------------+------------------------------
// request | in  | in_tvalid/in_tready/in_tuser/ | tuser: kind; tdata: position,
//         |     | in_tdata                      | ir_length, id_value
// result  | out | out_tvalid/out_tready/        | tuser: status; tdata: count
//         |     | out_tuser/out_tdata           | and entry description
//
// One request at a time. A purge, get or rejected request goes from
// acceptance through the decode and load steps to its result. An insert at
// position p with c devices in the table also takes a shift step for each entry
// from c - 1 down to p, a drain step when c > p and a place step: the entry
// memory has a single read and a single write port, so entries move up one per
// cycle. Reset (rst_n, synchronous) clears the count and the total; the memory
// is not cleared, entries at or above the count are never read. A result waits
// in the output register while the next transaction is taken; a stalled result
// only holds the block if a new one is ready to load. Bits after an entry are
// derived from the total at read time, so no pass over the table is needed.
`timescale 1ns / 1ps

module scan_chain_tap_table #(
  parameter int MAX_DEVICES = sctt_pkg::MAX_DEVICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // kind [1:0]
  input  logic [sctt_pkg::KIND_W-1:0]     in_tuser,
  // position [4:0], ir_length [10:5], id_value [42:11], zero [47:43]
  input  logic [sctt_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status [1:0]
  output logic [sctt_pkg::STATUS_W-1:0]   out_tuser,
  // device_count [4:0], entry_position [8:5], entry_ir_length [14:9],
  // entry_ir_mask [46:15], entry_id [78:47], devices_before [82:79],
  // devices_after [86:83], ir_bits_before [95:87], ir_bits_after [104:96],
  // zero [111:105]
  output logic [sctt_pkg::OUT_DATA_W-1:0] out_tdata
);

  import sctt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing of each transaction
  sctt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // table storage, running sums and result formatting
  sctt_datapath #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

endmodule

/* rtl/sctt_datapath.sv */
// Datapath of the scan chain TAP table: request registers, entry memory,
// count and total registers, shift/place write port and the result register.
// Depends on sctt_pkg.
`timescale 1ns / 1ps

module sctt_datapath #(
  parameter int MAX_DEVICES = sctt_pkg::MAX_DEVICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [sctt_pkg::KIND_W-1:0]         in_tuser,
  input  logic [sctt_pkg::IN_DATA_W-1:0]      in_tdata,
  input  sctt_pkg::cmd_t                      cmd,
  output sctt_pkg::sts_t                      sts,
  output logic [sctt_pkg::STATUS_W-1:0]       out_tuser,
  output logic [sctt_pkg::OUT_DATA_W-1:0]     out_tdata
);

  import sctt_pkg::*;

  localparam int CW = $clog2(MAX_DEVICES + 1);
  localparam int IW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  // request
  logic [KIND_W-1:0]   kind_r;
  logic [PW-1:0]       pos_r;
  logic [LEN_W-1:0]    len_r;
  logic [ID_W-1:0]     id_r;
  logic [STATUS_W-1:0] status_r;

  // table state
  logic [CW-1:0]    count_r;
  logic [SUM_W-1:0] total_r;
  entry_t           mem [MAX_DEVICES];
  entry_t           rd_data_r;

  // shift sequencing
  logic [IW-1:0]    idx_r;
  logic [IW-1:0]    wr_addr_r;
  logic             pend_r;
  logic [SUM_W-1:0] before_p_r;

  logic [PW-1:0]       count_ext;
  logic [PW-1:0]       eff_pos;
  logic [STATUS_W-1:0] status_nxt;
  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  entry_t              wr_data;

  assign count_ext = PW'(count_r);
  assign eff_pos   = (kind_r == KIND_APPEND) ? count_ext : pos_r;

  always_comb begin
    case (kind_r)
      KIND_PURGE: begin
        status_nxt = ST_OK;
      end
      KIND_INSERT, KIND_APPEND: begin
        if (count_r == CW'(MAX_DEVICES)) begin
          status_nxt = ST_FULL;
        end else if (eff_pos > count_ext) begin
          status_nxt = ST_BADPOS;
        end else begin
          status_nxt = ST_OK;
        end
      end
      KIND_GET: begin
        status_nxt = (pos_r >= count_ext) ? ST_BADPOS : ST_OK;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  assign sts.is_purge     = (kind_r == KIND_PURGE);
  assign sts.is_get       = (kind_r == KIND_GET);
  assign sts.err          = (status_nxt != ST_OK);
  assign sts.shift_needed = (eff_pos < count_ext);
  assign sts.last_rd      = (PW'(idx_r) == pos_r);

  // request capture and table control registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_tuser;
      pos_r  <= PW'(in_tdata[POS_W-1:0]);
      len_r  <= in_tdata[POS_W +: LEN_W];
      id_r   <= in_tdata[POS_W + LEN_W +: ID_W];
    end
    if (cmd.decode) begin
      status_r   <= status_nxt;
      pos_r      <= eff_pos;
      idx_r      <= IW'(count_r - CW'(1));
      before_p_r <= total_r;
    end
    if (cmd.shift_rd) begin
      idx_r     <= idx_r - IW'(1);
      wr_addr_r <= idx_r + IW'(1);
    end
    if (cmd.drain) begin
      before_p_r <= rd_data_r.bits_ahead;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      pend_r <= cmd.shift_rd;
      if (cmd.decode && sts.is_purge) begin
        count_r <= '0;
        total_r <= '0;
      end else if (cmd.place) begin
        count_r <= count_r + CW'(1);
        total_r <= total_r + SUM_W'(len_r);
      end
    end
  end

  // entry memory: one read, one write port
  assign rd_en   = (cmd.decode && sts.is_get && !sts.err) || cmd.shift_rd;
  assign rd_addr = cmd.shift_rd ? idx_r : pos_r[IW-1:0];

  assign wr_en   = pend_r || cmd.place;
  assign wr_addr = cmd.place ? pos_r[IW-1:0] : wr_addr_r;

  always_comb begin
    if (cmd.place) begin
      wr_data.bits_ahead = before_p_r;
      wr_data.len        = len_r;
      wr_data.id         = id_r;
    end else begin
      // entries behind the new one gain its length ahead of them
      wr_data.bits_ahead = rd_data_r.bits_ahead + SUM_W'(len_r);
      wr_data.len        = rd_data_r.len;
      wr_data.id         = rd_data_r.id;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // result
  logic             show;
  entry_t           ent;
  logic [SUM_W-1:0] after_sum;
  logic [PW-1:0]    dev_after;

  assign show      = (status_r == ST_OK) && (kind_r != KIND_PURGE);
  assign ent       = (kind_r == KIND_GET) ? rd_data_r : entry_t'({before_p_r, len_r, id_r});
  assign after_sum = total_r - ent.bits_ahead - SUM_W'(ent.len);
  assign dev_after = count_ext - PW'(1) - pos_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tuser <= status_r;
      if (show) begin
        out_tdata <= {(OUT_DATA_W - OUT_FIELDS_W)'(0),
                      after_sum,
                      ent.bits_ahead,
                      dev_after[DEV_W-1:0],
                      pos_r[DEV_W-1:0],
                      ent.id,
                      ir_mask(ent.len),
                      ent.len,
                      pos_r[EPOS_W-1:0],
                      COUNT_W'(count_r)};
      end else begin
        out_tdata <= {(OUT_DATA_W - COUNT_W)'(0), COUNT_W'(count_r)};
      end
    end
  end

endmodule

/* rtl/sctt_ctrl.sv */
// Controller of the scan chain TAP table: sequences decode, shift, place and
// result load, and owns the input ready and output valid. Depends on sctt_pkg.
`timescale 1ns / 1ps

module sctt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  sctt_pkg::sts_t sts,
  output sctt_pkg::cmd_t cmd
);

  import sctt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_PLACE  = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.is_purge || sts.err || sts.is_get) begin
          state_nxt = S_FIN;
        end else if (sts.shift_needed) begin
          state_nxt = S_SHIFT;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_SHIFT: begin
        cmd.shift_rd = 1'b1;
        if (sts.last_rd) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.drain = 1'b1;
        state_nxt = S_PLACE;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
